// ===== hdl/euclidean_signed_divider_macros.svh =====
// assertion macros for the euclidean signed divider
// clocked on clk; ESD_ASSERT is disabled while arst_n is low
`ifndef EUCLIDEAN_SIGNED_DIVIDER_MACROS_SVH
`define EUCLIDEAN_SIGNED_DIVIDER_MACROS_SVH

`ifndef ASSERT_OFF
`define ESD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ESD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESD_ASSERT(lbl, prop, msg)
`define ESD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/esd_pkg.sv =====
`default_nettype none

package esd_pkg;

	// operand, quotient and step counter widths, last step index
	localparam int DATA_WIDTH  = 32;
	localparam int QUOT_WIDTH  = DATA_WIDTH + 1;
	localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);
	localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(DATA_WIDTH - 1);

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX
	} esd_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} esd_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/esd_in_if.sv =====
`default_nettype none

interface esd_in_if import esd_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] dividend;
	logic signed [DATA_WIDTH-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink (input valid, input dividend, input divisor, output ready);
endinterface

`default_nettype wire

// ===== hdl/esd_out_if.sv =====
`default_nettype none

interface esd_out_if import esd_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [QUOT_WIDTH-1:0] quotient;
	logic                         divide_by_zero;

	modport source (output valid, output quotient, output divide_by_zero, input ready);
	modport sink (input valid, input quotient, input divide_by_zero, output ready);
endinterface

`default_nettype wire

// ===== hdl/esd_datapath.sv =====
`default_nettype none

module esd_datapath import esd_pkg::*; (
	input  wire logic                         clk,
	input  wire esd_cmd_t                     cmd,
	input  wire logic signed [DATA_WIDTH-1:0] dividend,
	input  wire logic signed [DATA_WIDTH-1:0] divisor,
	output logic signed [QUOT_WIDTH-1:0]      quotient,
	output logic                              divide_by_zero
);

	logic [DATA_WIDTH-1:0] acc_q;   // dividend magnitude, becomes quotient
	logic [DATA_WIDTH-1:0] den_q;   // divisor magnitude
	logic [DATA_WIDTH-1:0] rem_q;   // partial remainder
	logic                  a_neg_q;
	logic                  b_neg_q;
	logic                  b_zero_q;
	logic signed [QUOT_WIDTH-1:0] quot_q;
	logic                  dbz_q;

	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  q_bit;
	logic [QUOT_WIDTH-1:0] q_ext;
	logic                  round_up;
	logic                  flip;
	logic [QUOT_WIDTH-1:0] q_fix;

	// operand magnitudes
	always_comb begin
		a_mag = dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-dividend) : DATA_WIDTH'(dividend);
		b_mag = divisor[DATA_WIDTH-1] ? DATA_WIDTH'(-divisor) : DATA_WIDTH'(divisor);
	end

	// one restoring step
	always_comb begin
		shifted = {rem_q, acc_q[DATA_WIDTH-1]};
		diff    = shifted - {1'b0, den_q};
		q_bit   = ~diff[DATA_WIDTH];
	end

	// sign fix: -(q + 1) is ~q, -q is ~q + 1
	always_comb begin
		q_ext    = {1'b0, acc_q};
		round_up = a_neg_q && (rem_q != '0);
		flip     = a_neg_q ^ b_neg_q;
		q_fix    = (flip ? ~q_ext : q_ext) + QUOT_WIDTH'(flip ? !round_up : round_up);
	end

	// operand and iteration registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q    <= a_mag;
			den_q    <= b_mag;
			rem_q    <= '0;
			a_neg_q  <= dividend[DATA_WIDTH-1];
			b_neg_q  <= divisor[DATA_WIDTH-1];
			b_zero_q <= (divisor == '0);
		end else if (cmd.step) begin
			rem_q <= q_bit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			acc_q <= {acc_q[DATA_WIDTH-2:0], q_bit};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			quot_q <= b_zero_q ? '0 : q_fix;
			dbz_q  <= b_zero_q;
		end
	end

	assign quotient       = quot_q;
	assign divide_by_zero = dbz_q;

endmodule

`default_nettype wire

// ===== hdl/esd_controller.sv =====
`default_nettype none

module esd_controller import esd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output esd_cmd_t  cmd
);

	esd_state_t state_q;
	esd_state_t state_next;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_next = ST_FIX;
				end
			end
			ST_FIX: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/euclidean_signed_divider.sv =====
// channel    dir  payload                           width
// operands   in   dividend, divisor                 32, 32 signed
// result     out  quotient, divide_by_zero          33 signed, 1
//
// a request runs in order: load with magnitudes, 32 restoring steps, sign fix
// the shared shift-subtract unit produces one quotient bit per cycle
// a new request is taken in the cycle after the sign fix, never while a division runs
// the result register holds while result.ready is low; the next division runs meanwhile
// arst_n clears the controller; operand and result payload registers are not reset
`default_nettype none

`include "euclidean_signed_divider_macros.svh"

module euclidean_signed_divider import esd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	esd_in_if.sink     operands,
	esd_out_if.source  result
);

	esd_cmd_t cmd;

	// sequencing
	esd_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// arithmetic
	esd_datapath u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.dividend       (operands.dividend),
		.divisor        (operands.divisor),
		.quotient       (result.quotient),
		.divide_by_zero (result.divide_by_zero)
	);

	// checks
	`ESD_ASSERT(a_busy_after_load, (operands.valid && operands.ready) |=> !operands.ready, "request taken while dividing")
	`ESD_ASSERT(a_zero_on_dbz, (result.valid && result.divide_by_zero) |-> (result.quotient == '0), "nonzero quotient on divide by zero")
	`ESD_ASSERT(a_finish_shows, cmd.finish |=> result.valid, "finished result not presented")
	`ESD_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "conflicting datapath commands")

endmodule

`default_nettype wire

// ===== bench/euclidean_signed_divider_tb.sv =====
module euclidean_signed_divider_tb import esd_pkg::*; ();

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	typedef struct packed {
		logic [QUOT_WIDTH-1:0] quotient;
		logic                  divide_by_zero;
	} euclid_result_t;

	logic clk;
	logic arst_n;

	esd_in_if  operands_bus ();
	esd_out_if result_bus ();

	euclidean_signed_divider DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_bus),
		.result   (result_bus)
	);

	euclid_result_t expected_quotients[$];
	int unsigned    mismatch_count;
	int unsigned    cycle_count;
	int unsigned    sender_idle_pct;
	int unsigned    receiver_idle_pct;
	int unsigned    receiver_hold_request;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// euclidean quotient of two signed operands
	function automatic euclid_result_t euclid_divide(logic [DATA_WIDTH-1:0] num,
			logic [DATA_WIDTH-1:0] den);
		logic                  num_neg;
		logic                  den_neg;
		logic [DATA_WIDTH-1:0] num_mag;
		logic [DATA_WIDTH-1:0] den_mag;
		logic [DATA_WIDTH-1:0] rem_mag;
		logic [QUOT_WIDTH-1:0] quot;
		euclid_result_t        res;
		num_neg = num[DATA_WIDTH-1];
		den_neg = den[DATA_WIDTH-1];
		num_mag = num_neg ? (~num + 1'b1) : num;
		den_mag = den_neg ? (~den + 1'b1) : den;
		if (den_mag == '0) begin
			res.quotient       = '0;
			res.divide_by_zero = 1'b1;
			return res;
		end
		quot    = {1'b0, num_mag / den_mag};
		rem_mag = num_mag % den_mag;
		// round the magnitude up so the true remainder stays nonnegative
		if (num_neg && rem_mag != '0)
			quot = quot + 1'b1;
		if (num_neg != den_neg)
			quot = ~quot + 1'b1;
		res.quotient       = quot;
		res.divide_by_zero = 1'b0;
		return res;
	endfunction

	// operand mix: full range, small values, corners, random magnitudes
	function automatic logic [DATA_WIDTH-1:0] random_operand();
		logic [DATA_WIDTH-1:0] v;
		case ($urandom_range(5))
			0, 1: v = $urandom();
			2: begin
				v = $urandom_range(20);
				if ($urandom_range(1))
					v = ~v + 1'b1;
			end
			3: begin
				case ($urandom_range(5))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = '0;
					3: v = '1;
					4: v = 1;
					default: v = MOST_NEG + 1'b1;
				endcase
			end
			default: begin
				v = $urandom() >> $urandom_range(DATA_WIDTH-1);
				if ($urandom_range(1))
					v = ~v + 1'b1;
			end
		endcase
		return v;
	endfunction

	// offer one request, with random idle cycles ahead of it
	task automatic send_division(input logic [DATA_WIDTH-1:0] num,
			input logic [DATA_WIDTH-1:0] den);
		while ($urandom_range(99) < sender_idle_pct) begin
			operands_bus.valid <= 1'b0;
			@(negedge clk);
		end
		operands_bus.valid    <= 1'b1;
		operands_bus.dividend <= num;
		operands_bus.divisor  <= den;
		@(posedge clk);
		while (!operands_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		operands_bus.valid <= 1'b0;
		while (expected_quotients.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random_phase(input int unsigned count, input int unsigned s_pct,
			input int unsigned r_pct);
		sender_idle_pct   = s_pct;
		receiver_idle_pct = r_pct;
		repeat (count)
			send_division(random_operand(), random_operand());
	endtask

	task automatic test_directed_corners();
		sender_idle_pct   = 15;
		receiver_idle_pct = 79;
		// zero dividend
		send_division(0, 5);
		send_division(0, -5);
		send_division(0, MOST_NEG);
		// zero divisor
		send_division(0, 0);
		send_division(5, 0);
		send_division(-5, 0);
		send_division(MOST_NEG, 0);
		send_division(MOST_POS, 0);
		// most negative dividend by minus one and other extremes
		send_division(MOST_NEG, -1);
		send_division(MOST_NEG, 1);
		send_division(MOST_POS, 1);
		send_division(MOST_POS, -1);
		send_division(MOST_NEG, MOST_NEG);
		send_division(MOST_POS, MOST_POS);
		send_division(MOST_NEG, MOST_POS);
		send_division(MOST_POS, MOST_NEG);
		// every sign combination inexact, then mixed-sign exact cases and extreme divisors
		send_division(7, 2);
		send_division(-7, 2);
		send_division(7, -2);
		send_division(-7, -2);
		send_division(-6, 3);
		send_division(6, -3);
		send_division(-1, MOST_NEG);
		send_division(1, MOST_NEG);
		send_division(-1, MOST_POS);
	endtask

	task automatic test_slow_receiver();
		run_random_phase(600, 15, 79);
	endtask

	task automatic test_slow_sender();
		run_random_phase(600, 79, 15);
	endtask

	task automatic test_full_rate();
		run_random_phase(600, 0, 0);
	endtask

	// long result stall while requests keep coming, so the input backs up
	task automatic test_result_stall();
		sender_idle_pct       = 0;
		receiver_idle_pct     = 0;
		receiver_hold_request = 600;
		repeat (10)
			send_division(random_operand(), random_operand());
	endtask

	// sender goes quiet until every pending result is out, then resumes
	task automatic test_drain_and_resume();
		run_random_phase(10, 0, 0);
		wait_for_drain();
		run_random_phase(10, 0, 0);
	endtask

	// result receiver with random stalls and requested long hold-offs
	initial begin : result_receiver
		int unsigned hold_left;
		hold_left        = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_hold_request != 0) begin
				hold_left             = receiver_hold_request;
				receiver_hold_request = 0;
			end
			if (hold_left != 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// check each result, then record the prediction for each accepted request
	always @(posedge clk) begin
		euclid_result_t want;
		if (arst_n) begin
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
				if (expected_quotients.size() == 0) begin
					$error("unexpected result: quotient %0d divide_by_zero %0b",
						$signed(result_bus.quotient), result_bus.divide_by_zero);
					mismatch_count++;
				end else begin
					want = expected_quotients.pop_front();
					if (result_bus.quotient !== want.quotient) begin
						$error("quotient: expected %0d actual %0d",
							$signed(want.quotient), $signed(result_bus.quotient));
						mismatch_count++;
					end
					if (result_bus.divide_by_zero !== want.divide_by_zero) begin
						$error("divide_by_zero: expected %0b actual %0b",
							want.divide_by_zero, result_bus.divide_by_zero);
						mismatch_count++;
					end
				end
			end
			if (operands_bus.valid === 1'b1 && operands_bus.ready === 1'b1)
				expected_quotients.push_back(euclid_divide(operands_bus.dividend,
					operands_bus.divisor));
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL euclidean_signed_divider");
			$finish;
		end
	end

	initial begin
		mismatch_count        = 0;
		cycle_count           = 0;
		sender_idle_pct       = 0;
		receiver_idle_pct     = 0;
		receiver_hold_request = 0;
		operands_bus.valid    = 1'b0;
		operands_bus.dividend = '0;
		operands_bus.divisor  = '0;
		arst_n                = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_corners();
		test_slow_receiver();
		test_slow_sender();
		test_full_rate();
		test_result_stall();
		test_drain_and_resume();

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_quotients.size() == 0)
			$display("PASS euclidean_signed_divider");
		else
			$display("FAIL euclidean_signed_divider");
		$finish;
	end

endmodule
